FILE: rtl/rgbhsv_pkg.sv
// Shared types, constants and sizing for the RGB to HSV/HSL converter.
// No dependencies; every other file in rtl/ imports this package.
package rgbhsv_pkg;

   localparam int CHANNEL_BITS = 8;
   localparam int FRAC_BITS    = 16;

   localparam logic [CHANNEL_BITS-1:0] CH_FULL   = {CHANNEL_BITS{1'b1}};
   localparam logic [FRAC_BITS-1:0]    FRAC_FULL = {FRAC_BITS{1'b1}};
   localparam int LEVEL_MUL_INT = ((1 << FRAC_BITS) - 1) / ((1 << CHANNEL_BITS) - 1);
   localparam int LEVEL_MUL_BITS = FRAC_BITS - CHANNEL_BITS + 1;
   localparam logic [LEVEL_MUL_BITS-1:0] LEVEL_MUL = LEVEL_MUL_BITS'(LEVEL_MUL_INT);

   // hue divisor 6*C and the running remainder
   localparam int HNUM_BITS = CHANNEL_BITS + 3;
   localparam int HREM_BITS = CHANNEL_BITS + 4;
   // saturation dividend C*FRAC_FULL, divisor up to CH_FULL
   localparam int SNUM_BITS = CHANNEL_BITS + FRAC_BITS;
   localparam int SDEN_BITS = CHANNEL_BITS + 1;
   localparam int SREM_BITS = CHANNEL_BITS + 2;

   localparam int STEPS_PER_STAGE = 4;
   localparam int DIV_STAGES = (SNUM_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
   localparam int TOTAL_STEPS = DIV_STAGES * STEPS_PER_STAGE;
   localparam int HUE_START = TOTAL_STEPS - FRAC_BITS;
   localparam int SAT_START = TOTAL_STEPS - SNUM_BITS;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic MODE_HSV = 1'b0;
   localparam logic MODE_HSL = 1'b1;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [FRAC_BITS-1:0] hue;
      logic [FRAC_BITS-1:0] saturation;
      logic [FRAC_BITS-1:0] level;
   } color_type;

   typedef struct packed {
      logic [HNUM_BITS-1:0] hue_num;
      logic [HNUM_BITS-1:0] hue_den;
      logic [SNUM_BITS-1:0] sat_num;
      logic [SDEN_BITS-1:0] sat_den;
      logic [FRAC_BITS-1:0] level;
   } work_type;

   typedef struct packed {
      logic [HNUM_BITS-1:0] hrem;
      logic [HNUM_BITS-1:0] hden;
      logic [FRAC_BITS-1:0] hq;
      logic [SDEN_BITS-1:0] srem;
      logic [SDEN_BITS-1:0] sden;
      logic [SNUM_BITS-1:0] sdiv;
      logic [FRAC_BITS-1:0] sq;
      logic [FRAC_BITS-1:0] level;
   } stage_type;

endpackage

FILE: rtl/rgb_to_hsv_hsl_core.sv
// Top level of the RGB to HSV/HSL converter: front end, request queue,
// divider pipeline and mode register. Depends on rgbhsv_pkg and the rgbhsv_* modules.
//
//  channel  ports                            direction  meaning
//  req      req_valid req_stall req_data     in         one RGB pixel
//  rsp      rsp_valid rsp_stall rsp_data     out        hue, saturation, level
//  csr      csr_valid csr_ready csr_data     in         mode: 0 HSV, 1 HSL
//
// One pixel per cycle sustained while rsp_stall is low; a request is written into
// a queue entry, moves from the queue into the first divider stage and then
// through each further stage to rsp_valid (DIV_STAGES = 6 stages of four
// quotient bits each, set by the 24-bit saturation dividend).
// Reset clears the queue, the pipeline valids and mode; no clearing pass.
// rsp_stall with rsp_valid holds the whole divider pipeline; the two-entry queue absorbs
// requests until it fills, then req_stall rises.
module rgb_to_hsv_hsl_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rgbhsv_pkg::pixel_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rgbhsv_pkg::color_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_data
);
   import rgbhsv_pkg::*;

   logic     mode_ff, mode_in;
   work_type front_work, head_work;
   logic     q_full, q_empty, q_push, q_pop;

   assign csr_ready = 1'b1;
   assign mode_in   = (csr_valid && csr_ready) ? csr_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_HSV;
      end else begin
         mode_ff <= mode_in;
      end
   end

   rgbhsv_front u_front (
      .pixel (req_data),
      .mode  (mode_ff),
      .work  (front_work)
   );

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   rgbhsv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_work),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (head_work)
   );

   rgbhsv_divpipe u_divpipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!q_empty),
      .in_work   (head_work),
      .in_take   (q_pop),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_color (rsp_data)
   );

endmodule

FILE: rtl/rgbhsv_front.sv
// Front end: max/min/chroma, hue sector, divider operands and level.
// Depends on rgbhsv_pkg.
module rgbhsv_front (
   input  rgbhsv_pkg::pixel_type pixel,
   input  logic                  mode,
   output rgbhsv_pkg::work_type  work
);
   import rgbhsv_pkg::*;

   logic [CHANNEL_BITS-1:0]   hi, lo;
   logic [CHANNEL_BITS-1:0]   c;
   logic [CHANNEL_BITS:0]     sum;
   logic [HNUM_BITS-1:0]      r_w, g_w, b_w, c_w, num;
   logic [SDEN_BITS-1:0]      den;
   logic [FRAC_BITS:0]        lprod;

   always_comb begin
      hi = pixel.red;
      lo = pixel.red;
      if (pixel.green > hi) hi = pixel.green;
      if (pixel.blue > hi) hi = pixel.blue;
      if (pixel.green < lo) lo = pixel.green;
      if (pixel.blue < lo) lo = pixel.blue;
      c   = hi - lo;
      sum = {1'b0, hi} + {1'b0, lo};

      r_w = HNUM_BITS'(pixel.red);
      g_w = HNUM_BITS'(pixel.green);
      b_w = HNUM_BITS'(pixel.blue);
      c_w = HNUM_BITS'(c);

      // sector numerators, all nonnegative and below 6C
      if (pixel.green == hi) begin
         num = b_w + (c_w << 1) - r_w;
      end else if (pixel.blue == hi) begin
         num = (c_w << 2) + r_w - g_w;
      end else if (pixel.green >= pixel.blue) begin
         num = g_w - b_w;
      end else begin
         num = (c_w << 2) + (c_w << 1) + g_w - b_w;
      end

      if (c == '0) begin
         work.hue_num = '0;
         work.hue_den = HNUM_BITS'(1);
      end else begin
         work.hue_num = num;
         work.hue_den = (c_w << 2) + (c_w << 1);
      end

      if (mode == MODE_HSV) begin
         den = SDEN_BITS'(hi);
      end else if (sum <= {1'b0, CH_FULL}) begin
         den = sum;
      end else begin
         den = {CH_FULL, 1'b0} - sum;
      end

      // black, or white in HSL, leaves a zero divisor: force saturation 0
      if (den == '0) begin
         work.sat_num = '0;
         work.sat_den = SDEN_BITS'(1);
      end else begin
         work.sat_num = SNUM_BITS'(c) * SNUM_BITS'(FRAC_FULL);
         work.sat_den = den;
      end

      if (mode == MODE_HSV) begin
         lprod = (FRAC_BITS+1)'(hi) * (FRAC_BITS+1)'(LEVEL_MUL);
         work.level = lprod[FRAC_BITS-1:0];
      end else begin
         lprod = (FRAC_BITS+1)'(sum) * (FRAC_BITS+1)'(LEVEL_MUL);
         work.level = lprod[FRAC_BITS:1];
      end
   end

endmodule

FILE: rtl/rgbhsv_queue.sv
// Two-entry request queue between the front end and the divider pipeline.
// Depends on rgbhsv_pkg.
module rgbhsv_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rgbhsv_pkg::work_type push_data,
   input  logic                 pop,
   output logic                 full,
   output logic                 empty,
   output rgbhsv_pkg::work_type head
);
   import rgbhsv_pkg::*;

   work_type             mem [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + QCNT_BITS'(push) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_data;
      end
   end

   assign full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem[rd_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop) else $error("queue pop while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_BITS'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

FILE: rtl/rgbhsv_divpipe.sv
// Back end: pipelined restoring dividers for hue and saturation, up to four
// quotient bits per stage, with the final stage as the output register.
// Depends on rgbhsv_pkg.
module rgbhsv_divpipe (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  rgbhsv_pkg::work_type  in_work,
   output logic                  in_take,
   output logic                  out_valid,
   input  logic                  out_stall,
   output rgbhsv_pkg::color_type out_color
);
   import rgbhsv_pkg::*;

   stage_type stage_ff [DIV_STAGES];
   stage_type stage_in [DIV_STAGES];
   logic [DIV_STAGES-1:0] valid_ff, valid_in;
   logic                  advance;
   stage_type             src;
   logic [HREM_BITS-1:0]  ht;
   logic [SREM_BITS-1:0]  st;

   // whole pipeline moves together; hold it while the result is stalled
   assign advance = !valid_ff[DIV_STAGES-1] || !out_stall;
   assign in_take = advance && in_valid;

   always_comb begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (s == 0) begin
            src.hrem  = in_work.hue_num;
            src.hden  = in_work.hue_den;
            src.hq    = '0;
            src.srem  = '0;
            src.sden  = in_work.sat_den;
            src.sdiv  = in_work.sat_num;
            src.sq    = '0;
            src.level = in_work.level;
            valid_in[s] = in_valid;
         end else begin
            src = stage_ff[s-1];
            valid_in[s] = valid_ff[s-1];
         end
         for (int j = 0; j < STEPS_PER_STAGE; j++) begin
            if (s * STEPS_PER_STAGE + j >= HUE_START) begin
               ht = {src.hrem, 1'b0};
               if (ht >= HREM_BITS'(src.hden)) begin
                  src.hrem = HNUM_BITS'(ht - HREM_BITS'(src.hden));
                  src.hq   = {src.hq[FRAC_BITS-2:0], 1'b1};
               end else begin
                  src.hrem = HNUM_BITS'(ht);
                  src.hq   = {src.hq[FRAC_BITS-2:0], 1'b0};
               end
            end
            if (s * STEPS_PER_STAGE + j >= SAT_START) begin
               st = {src.srem, src.sdiv[SNUM_BITS-1]};
               src.sdiv = {src.sdiv[SNUM_BITS-2:0], 1'b0};
               if (st >= SREM_BITS'(src.sden)) begin
                  src.srem = SDEN_BITS'(st - SREM_BITS'(src.sden));
                  src.sq   = {src.sq[FRAC_BITS-2:0], 1'b1};
               end else begin
                  src.srem = SDEN_BITS'(st);
                  src.sq   = {src.sq[FRAC_BITS-2:0], 1'b0};
               end
            end
         end
         stage_in[s] = src;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign out_valid            = valid_ff[DIV_STAGES-1];
   assign out_color.hue        = stage_ff[DIV_STAGES-1].hq;
   assign out_color.saturation = stage_ff[DIV_STAGES-1].sq;
   assign out_color.level      = stage_ff[DIV_STAGES-1].level;

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_stall |=> out_valid && $stable(out_color))
      else $error("stalled result changed");
   a_take_needs_room: assert property (@(posedge clock) disable iff (reset)
      in_take |-> !(valid_ff[DIV_STAGES-1] && out_stall))
      else $error("pipeline took work while blocked");
   a_fill_moves: assert property (@(posedge clock) disable iff (reset)
      in_take |=> valid_ff[0]) else $error("taken request lost in first stage");

endmodule

FILE: bench/testbench.sv
// Self-checking bench for rgb_to_hsv_hsl_core: drives pixels, predicts hue,
// saturation and level in both modes, compares responses. Depends on rgbhsv_pkg.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import rgbhsv_pkg::*;

   localparam int LATENCY = DIV_STAGES + 2;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_COUNT = 850;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   pixel_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   color_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_data = 1'b0;

   rgb_to_hsv_hsl_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   pixel_type pending_pixels[$];
   color_type expected_colors[$];
   logic      color_mode = MODE_HSV;
   int        send_idle_pct = 0;
   int        recv_stall_pct = 0;
   int        errors = 0;
   int        quiet_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [FRAC_BITS-1:0] frac_of(longint unsigned num,
                                                     longint unsigned den);
      longint unsigned q;
      if (den == 0) return '0;
      q = num * FRAC_FULL / den;
      return (q > FRAC_FULL) ? FRAC_FULL : q[FRAC_BITS-1:0];
   endfunction

   function automatic color_type convert_pixel(pixel_type px, logic mode_sel);
      longint unsigned r, g, b, hi, lo, chroma, num, hq, sum;
      color_type res;
      r = 64'(px.red); g = 64'(px.green); b = 64'(px.blue);
      hi = r; lo = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      chroma = hi - lo;
      if (chroma == 0) begin
         hq = 0;
      end else begin
         if (g == hi) num = b + 2 * chroma - r;
         else if (b == hi) num = 4 * chroma + r - g;
         else if (g >= b) num = g - b;
         else num = 6 * chroma + g - b;
         hq = (num << FRAC_BITS) / (6 * chroma);
         if (hq > FRAC_FULL) hq = FRAC_FULL;
      end
      res.hue = hq[FRAC_BITS-1:0];
      sum = hi + lo;
      if (mode_sel == MODE_HSV) begin
         res.saturation = (hi == 0) ? '0 : frac_of(chroma, hi);
         res.level = FRAC_BITS'(hi * FRAC_FULL / CH_FULL);
      end else begin
         if (hi == 0 || lo == CH_FULL) res.saturation = '0;
         else if (sum <= CH_FULL) res.saturation = frac_of(chroma, sum);
         else res.saturation = frac_of(chroma, 2 * CH_FULL - sum);
         res.level = FRAC_BITS'(sum * FRAC_FULL / (2 * CH_FULL));
      end
      return res;
   endfunction

   // driver: advance to the next pixel only after acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_colors.push_back(convert_pixel(req_data, color_mode));
            void'(pending_pixels.pop_front());
         end
         // hold a stalled request; otherwise present the head or idle
         if (!(req_valid && req_stall)) begin
            if (pending_pixels.size() > 0 && ($urandom_range(99) >= send_idle_pct)) begin
               req_valid <= 1'b1;
               req_data <= pending_pixels[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      color_type want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (expected_colors.size() == 0) begin
               errors++;
               $display("%0t: expected no response, actual %h", $time, rsp_data);
            end else begin
               want = expected_colors.pop_front();
               if (rsp_data.hue !== want.hue) begin
                  errors++;
                  $display("%0t: hue expected %h actual %h", $time, want.hue, rsp_data.hue);
               end
               if (rsp_data.saturation !== want.saturation) begin
                  errors++;
                  $display("%0t: saturation expected %h actual %h", $time,
                           want.saturation, rsp_data.saturation);
               end
               if (rsp_data.level !== want.level) begin
                  errors++;
                  $display("%0t: level expected %h actual %h", $time,
                           want.level, rsp_data.level);
               end
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL rgb_to_hsv_hsl_core");
            $finish;
         end
      end
   end

   task automatic push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      pixel_type px;
      px.red = r; px.green = g; px.blue = b;
      pending_pixels.push_back(px);
   endtask

   task automatic drain();
      while (pending_pixels.size() != 0 || req_valid || expected_colors.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_mode(logic value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      color_mode = value;
   endtask

   task automatic push_directed();
      push_pixel(8'h00, 8'h00, 8'h00);
      push_pixel(8'hff, 8'hff, 8'hff);
      push_pixel(8'h80, 8'h80, 8'h80);
      push_pixel(8'hff, 8'h00, 8'h00);
      push_pixel(8'h00, 8'hff, 8'h00);
      push_pixel(8'h00, 8'h00, 8'hff);
      push_pixel(8'hff, 8'hff, 8'h00);
      push_pixel(8'h00, 8'hff, 8'hff);
      push_pixel(8'hff, 8'h00, 8'hff);
      push_pixel(8'hff, 8'h00, 8'h01);
      push_pixel(8'hff, 8'h01, 8'h00);
      push_pixel(8'h01, 8'h00, 8'h00);
      push_pixel(8'hfe, 8'hff, 8'hff);
      push_pixel(8'hff, 8'hfe, 8'hfe);
      push_pixel(8'h7f, 8'h80, 8'h00);
      push_pixel(8'h55, 8'haa, 8'h01);
   endtask

   task automatic run_random(int count);
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(3))
            0: push_pixel(8'($urandom), 8'($urandom), 8'($urandom));
            1: begin
               logic [7:0] v;
               v = 8'($urandom);
               push_pixel(v, 8'(v + 8'($urandom_range(2))), 8'(v - 8'($urandom_range(2))));
            end
            2: push_pixel($urandom_range(1) ? 8'hff : 8'h00, 8'($urandom), 8'($urandom));
            default: push_pixel(8'($urandom_range(3)), 8'($urandom_range(3)), 8'($urandom));
         endcase
      end
      drain();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      push_directed();
      drain();
      write_mode(MODE_HSL);
      push_directed();
      drain();
      // each group of four phases: no idling, sender idles, receiver stalls, then both
      for (int phase = 0; phase < 8; phase++) begin
         send_idle_pct = (phase % 4 == 1 || phase % 4 == 3) ? ((phase % 4 == 3) ? 26 : 50) : 0;
         recv_stall_pct = (phase % 4 == 2) ? 50 : ((phase % 4 == 3) ? 26 : 0);
         if (phase == 4) write_mode(MODE_HSV);
         if (phase == 6) write_mode(MODE_HSL);
         run_random(RANDOM_COUNT / 8);
      end
      if (errors == 0) begin
         $display("PASS rgb_to_hsv_hsl_core");
      end else begin
         $display("FAIL rgb_to_hsv_hsl_core");
      end
      $finish;
   end

endmodule
